// File: hdl/bstc_pkg.sv
`timescale 1ns / 1ps

package bstc_pkg;

   // Codec modes as held in the mode register.
   typedef enum logic [1:0] {
      MODE_PASS   = 2'd0,
      MODE_BASE64 = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_XOR    = 2'd3
   } bstc_mode_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_DIRECTION = 2'd1;
   localparam logic [1:0] CSR_XOR_KEY   = 2'd2;

   localparam logic       DIR_ENCODE = 1'b0;
   localparam logic       DIR_DECODE = 1'b1;

   localparam logic [31:0] XOR_KEY_RESET = 32'hDEADBEEF;
   localparam logic [7:0]  PAD_CHAR      = 8'h3D;

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified request: up to four results, first in data[0].
   // A status job carries one result with no data and the error flag.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic            last;
      logic            status;
   } bstc_job_type;

   // Base64 alphabet lookup for one sextet.
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // Base64 character to sextet; anything outside the alphabet gives zero.
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         v = 8'd62;
      end else if (c == 8'h2F) begin
         v = 8'd63;
      end else begin
         v = 8'd0;
      end
      return v[5:0];
   endfunction

   // Hex digit of either case to nibble; anything else gives zero.
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h61 + 8'd10;
      end else begin
         v = 8'd0;
      end
      return v[3:0];
   endfunction

   // Nibble to upper-case hex digit.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h41 + {4'h0, n} - 8'd10;
      end
      return c;
   endfunction

endpackage

// File: hdl/bstc_front.sv
`timescale 1ns / 1ps

module bstc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 queue_full,
   output logic                 push,
   output bstc_pkg::bstc_job_type job
);
   import bstc_pkg::*;

   bstc_mode_type mode_ff, mode_in;
   logic          dir_ff, dir_in;
   logic [31:0]   key_ff, key_in;
   logic [23:0]   buf_ff, buf_in;
   logic [1:0]    fill_ff, fill_in;
   logic          pad_ff, pad_in;
   logic [1:0]    kpos_ff, kpos_in;

   logic          accept;

   assign accept = req_valid && !queue_full;

   // Classify the request, update the group state and build its job.
   always_comb begin
      logic [23:0] grp;
      logic [2:0]  n;
      logic [5:0]  sx;
      logic        keep2;
      logic        keep3;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;

      mode_in = mode_ff;
      dir_in  = dir_ff;
      key_in  = key_ff;
      buf_in  = buf_ff;
      fill_in = fill_ff;
      pad_in  = pad_ff;
      kpos_in = kpos_ff;
      push    = 1'b0;
      job     = '0;
      grp     = '0;
      n       = '0;
      sx      = sextet_of(req_in_byte);
      keep2   = 1'b0;
      keep3   = 1'b0;
      b0      = '0;
      b1      = '0;
      b2      = '0;

      if (accept) begin
         job.last = req_in_last;
         case (mode_ff)
            MODE_BASE64: begin
               if (dir_ff == DIR_ENCODE) begin
                  // Gather up to three bytes, then emit four characters.
                  case (fill_ff)
                     2'd0:    grp = {req_in_byte, 16'h0000};
                     2'd1:    grp = {buf_ff[23:16], req_in_byte, 8'h00};
                     default: grp = {buf_ff[23:8], req_in_byte};
                  endcase
                  n = {1'b0, fill_ff} + 3'd1;
                  if (n < 3'd3 && !req_in_last) begin
                     buf_in  = grp;
                     fill_in = n[1:0];
                  end else begin
                     push        = 1'b1;
                     job.count   = 3'd4;
                     job.data[0] = b64_char(grp[23:18]);
                     job.data[1] = b64_char(grp[17:12]);
                     job.data[2] = (n >= 3'd2) ? b64_char(grp[11:6]) : PAD_CHAR;
                     job.data[3] = (n >= 3'd3) ? b64_char(grp[5:0]) : PAD_CHAR;
                     buf_in      = '0;
                     fill_in     = '0;
                  end
               end else begin
                  // Gather four sextets, then emit the bytes that the pads keep.
                  if (fill_ff != 2'd3) begin
                     case (fill_ff)
                        2'd0:    buf_in = buf_ff | {sx, 18'h0};
                        2'd1:    buf_in = buf_ff | {6'h0, sx, 12'h0};
                        default: buf_in = buf_ff | {12'h0, sx, 6'h0};
                     endcase
                     if (fill_ff == 2'd2 && req_in_byte == PAD_CHAR) begin
                        pad_in = 1'b1;
                     end
                     fill_in = fill_ff + 2'd1;
                     if (req_in_last) begin
                        push       = 1'b1;
                        job.count  = 3'd1;
                        job.status = 1'b1;
                     end
                  end else begin
                     grp   = buf_ff | {18'h0, sx};
                     b0    = grp[23:16];
                     b1    = grp[15:8];
                     b2    = grp[7:0];
                     keep2 = !pad_ff;
                     keep3 = (req_in_byte != PAD_CHAR);
                     push  = 1'b1;
                     job.data[0] = b0;
                     if (keep2 && keep3) begin
                        job.data[1] = b1;
                        job.data[2] = b2;
                        job.count   = 3'd3;
                     end else if (keep2) begin
                        job.data[1] = b1;
                        job.count   = 3'd2;
                     end else if (keep3) begin
                        job.data[1] = b2;
                        job.count   = 3'd2;
                     end else begin
                        job.count   = 3'd1;
                     end
                     buf_in  = '0;
                     fill_in = '0;
                     pad_in  = 1'b0;
                  end
               end
            end
            MODE_HEX: begin
               if (dir_ff == DIR_ENCODE) begin
                  push        = 1'b1;
                  job.count   = 3'd2;
                  job.data[0] = hex_char(req_in_byte[7:4]);
                  job.data[1] = hex_char(req_in_byte[3:0]);
               end else if (!fill_ff[0]) begin
                  // High nibble waits for its partner.
                  buf_in  = {20'h0, nibble_of(req_in_byte)};
                  fill_in = 2'd1;
                  if (req_in_last) begin
                     push       = 1'b1;
                     job.count  = 3'd1;
                     job.status = 1'b1;
                  end
               end else begin
                  push        = 1'b1;
                  job.count   = 3'd1;
                  job.data[0] = {buf_ff[3:0], nibble_of(req_in_byte)};
                  buf_in      = '0;
                  fill_in     = '0;
               end
            end
            MODE_XOR: begin
               push        = 1'b1;
               job.count   = 3'd1;
               job.data[0] = req_in_byte ^ key_ff[{kpos_ff, 3'b000} +: 8];
               kpos_in     = kpos_ff + 2'd1;
            end
            default: begin
               push        = 1'b1;
               job.count   = 3'd1;
               job.data[0] = req_in_byte;
            end
         endcase

         // The end of a stream clears all stream state.
         if (req_in_last) begin
            buf_in  = '0;
            fill_in = '0;
            pad_in  = 1'b0;
            kpos_in = '0;
         end
      end

      // Register writes; mode and direction restart the stream.
      if (csr_write) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = bstc_mode_type'(csr_data[1:0]);
               buf_in  = '0;
               fill_in = '0;
               pad_in  = 1'b0;
               kpos_in = '0;
            end
            CSR_DIRECTION: begin
               dir_in  = csr_data[0];
               buf_in  = '0;
               fill_in = '0;
               pad_in  = 1'b0;
               kpos_in = '0;
            end
            CSR_XOR_KEY: begin
               key_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
         dir_ff  <= DIR_ENCODE;
         key_ff  <= XOR_KEY_RESET;
         buf_ff  <= '0;
         fill_ff <= '0;
         pad_ff  <= 1'b0;
         kpos_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         dir_ff  <= dir_in;
         key_ff  <= key_in;
         buf_ff  <= buf_in;
         fill_ff <= fill_in;
         pad_ff  <= pad_in;
         kpos_ff <= kpos_in;
      end
   end

endmodule

// File: hdl/bstc_queue.sv
`timescale 1ns / 1ps

module bstc_queue #(
   parameter int DEPTH = bstc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bstc_pkg::bstc_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output bstc_pkg::bstc_job_type head_job
);
   import bstc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bstc_job_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hdl/bstc_back.sv
`timescale 1ns / 1ps

module bstc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  bstc_pkg::bstc_job_type head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_valid,
   output logic                   rsp_out_last,
   output logic                   rsp_codec_error
);
   import bstc_pkg::*;

   bstc_job_type job_ff, job_in;
   logic         busy_ff, busy_in;
   logic [1:0]   pos_ff, pos_in;
   logic         final_one;
   logic         taken;

   assign final_one = ({1'b0, pos_ff} == job_ff.count - 3'd1);
   assign taken     = busy_ff && !rsp_stall;
   assign pop       = head_valid && (!busy_ff || (taken && final_one));

   // Results leave one a cycle from the held job while the response port is not stalled.
   assign rsp_valid       = busy_ff;
   assign rsp_out_byte    = job_ff.data[pos_ff];
   assign rsp_out_valid   = !job_ff.status;
   assign rsp_out_last    = final_one && job_ff.last;
   assign rsp_codec_error = job_ff.status;

   // Step through the job; load the next one when idle or as the current one ends.
   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (taken) begin
         if (final_one) begin
            busy_in = 1'b0;
            pos_in  = '0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      if (pop) begin
         job_in  = head_job;
         busy_in = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

// File: hdl/byte_stream_text_codec_unit.sv
`timescale 1ns / 1ps

// Streaming byte codec for passthrough, base64, hex and four-byte-key XOR, in
// either direction, selected by the mode and direction registers. A request
// carries one byte and a last flag. The front stage classifies each request in
// the cycle it arrives and, when the request completes a group, places a job
// of one to four results in a short queue; the back stage sends those results
// one per cycle on the response channel while it is not stalled. Requests are
// taken every cycle while the queue has room, so the sustained rate is set by
// the response port: passthrough and XOR give one response per request, hex
// encode two, hex decode one per two characters, base64 encode four per three
// bytes and base64 decode up to three per four characters. A stream that ends
// inside an incomplete base64 decode or hex decode group returns one status
// response with the error flag and no data. Write the registers only while
// the block is idle; a write to mode or direction restarts the stream.
module byte_stream_text_codec_unit #(
   parameter int QUEUE_DEPTH = bstc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_out_last,
   output logic        rsp_codec_error,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bstc_pkg::*;

   bstc_job_type front_job;
   bstc_job_type head_job;
   logic         push;
   logic         full;
   logic         pop;
   logic         head_valid;

   assign req_stall = full;

   // Front: request intake, group state and job building.
   bstc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (full),
      .push        (push),
      .job         (front_job)
   );

   // Job queue between the two stages.
   bstc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (front_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: one response per cycle while the response port does not stall.
   bstc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_last    (rsp_out_last),
      .rsp_codec_error (rsp_codec_error)
   );

endmodule

// File: dv/codec_stream_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the codec, keeps its own
// copy of the stream state and compares every response with the prediction.
module codec_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_valid,
   input  logic        rsp_out_last,
   input  logic        rsp_codec_error,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatch_count,
   output int          outstanding
);
   import bstc_pkg::*;

   localparam logic [511:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       err;
   } codec_out_type;

   // Responses predicted but not yet seen, oldest first.
   codec_out_type predicted_outputs[$];

   // Register copies and stream state.
   bstc_mode_type cur_mode = MODE_PASS;
   logic          cur_dir  = DIR_ENCODE;
   logic [31:0]   cur_key  = XOR_KEY_RESET;
   logic [23:0]   grp_buf  = '0;
   logic [1:0]    grp_fill = '0;
   logic [1:0]    pad_flag = '0;
   logic [1:0]    key_pos  = '0;

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      int idx;
      idx = 63 - int'(v);
      return B64_ALPHABET[8*idx +: 8];
   endfunction

   function automatic logic [7:0] hex_symbol(input logic [3:0] v);
      int idx;
      idx = 15 - int'(v);
      return HEX_DIGITS[8*idx +: 8];
   endfunction

   // Characters outside the alphabet, the pad included, count as zero.
   function automatic logic [5:0] sextet_value(input logic [7:0] c);
      logic [7:0] r;
      r = 8'd0;
      if (c >= "A" && c <= "Z") r = c - "A";
      else if (c >= "a" && c <= "z") r = c - "a" + 8'd26;
      else if (c >= "0" && c <= "9") r = c - "0" + 8'd52;
      else if (c == "+") r = 8'd62;
      else if (c == "/") r = 8'd63;
      return r[5:0];
   endfunction

   function automatic logic [3:0] nibble_value(input logic [7:0] c);
      logic [7:0] r;
      r = 8'd0;
      if (c >= "0" && c <= "9") r = c - "0";
      else if (c >= "A" && c <= "F") r = c - "A" + 8'd10;
      else if (c >= "a" && c <= "f") r = c - "a" + 8'd10;
      return r[3:0];
   endfunction

   task automatic push_out(input logic [7:0] d, input logic v, input logic l,
                           input logic e);
      codec_out_type item;
      item.data = d;
      item.valid = v;
      item.last = l;
      item.err = e;
      predicted_outputs.push_back(item);
   endtask

   task automatic clear_stream();
      grp_buf = '0;
      grp_fill = '0;
      pad_flag = '0;
      key_pos = '0;
   endtask

   // Base64 decode gathers four sextets, then emits one to three bytes.
   task automatic predict_b64_decode(input logic [7:0] c, input logic lst);
      logic [23:0] t;
      logic [1:0]  pos;
      logic        keep_mid;
      logic        keep_low;
      int          sh;
      pos = grp_fill;
      if (pos != 2'd3) begin
         sh = 18 - 6 * int'(pos);
         grp_buf = grp_buf | ({18'd0, sextet_value(c)} << sh);
         if (pos == 2'd2 && c == PAD_CHAR) pad_flag[0] = 1'b1;
         grp_fill = pos + 2'd1;
         if (lst) push_out(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
         t = grp_buf | {18'd0, sextet_value(c)};
         keep_mid = !pad_flag[0];
         keep_low = (c != PAD_CHAR);
         push_out(t[23:16], 1'b1, lst && !keep_mid && !keep_low, 1'b0);
         if (keep_mid) push_out(t[15:8], 1'b1, lst && !keep_low, 1'b0);
         if (keep_low) push_out(t[7:0], 1'b1, lst, 1'b0);
         grp_buf = '0;
         grp_fill = '0;
         pad_flag = '0;
      end
   endtask

   // Base64 encode gathers up to three bytes and pads a short final group.
   task automatic predict_b64_encode(input logic [7:0] b, input logic lst);
      logic [23:0] t;
      logic [2:0]  n;
      int          sh;
      sh = 16 - 8 * int'(grp_fill);
      grp_buf = grp_buf | ({16'd0, b} << sh);
      n = {1'b0, grp_fill} + 3'd1;
      if (n < 3'd3 && !lst) begin
         grp_fill = n[1:0];
      end else begin
         t = grp_buf;
         push_out(b64_symbol(t[23:18]), 1'b1, 1'b0, 1'b0);
         push_out(b64_symbol(t[17:12]), 1'b1, 1'b0, 1'b0);
         push_out(n >= 3'd2 ? b64_symbol(t[11:6]) : PAD_CHAR, 1'b1, 1'b0, 1'b0);
         push_out(n >= 3'd3 ? b64_symbol(t[5:0]) : PAD_CHAR, 1'b1, lst, 1'b0);
         grp_buf = '0;
         grp_fill = '0;
      end
   endtask

   // Works out the responses caused by one accepted request.
   task automatic predict_request(input logic [7:0] b, input logic lst);
      case (cur_mode)
         MODE_BASE64: begin
            if (cur_dir == DIR_DECODE) predict_b64_decode(b, lst);
            else predict_b64_encode(b, lst);
         end
         MODE_HEX: begin
            if (cur_dir == DIR_DECODE) begin
               if (!grp_fill[0]) begin
                  grp_buf = {20'd0, nibble_value(b)};
                  grp_fill = 2'd1;
                  if (lst) push_out(8'h00, 1'b0, 1'b1, 1'b1);
               end else begin
                  push_out({grp_buf[3:0], nibble_value(b)}, 1'b1, lst, 1'b0);
                  grp_buf = '0;
                  grp_fill = '0;
               end
            end else begin
               push_out(hex_symbol(b[7:4]), 1'b1, 1'b0, 1'b0);
               push_out(hex_symbol(b[3:0]), 1'b1, lst, 1'b0);
            end
         end
         MODE_XOR: begin
            push_out(b ^ cur_key[8*int'(key_pos) +: 8], 1'b1, lst, 1'b0);
            key_pos = key_pos + 2'd1;
         end
         default: begin
            push_out(b, 1'b1, lst, 1'b0);
         end
      endcase
      if (lst) clear_stream();
   endtask

   always @(posedge clock) begin
      codec_out_type want;
      bit            bad;
      if (reset) begin
         cur_mode = MODE_PASS;
         cur_dir = DIR_ENCODE;
         cur_key = XOR_KEY_RESET;
         clear_stream();
         predicted_outputs.delete();
      end else begin
         // Register writes; mode and direction restart the stream.
         if (csr_write) begin
            case (csr_index)
               CSR_MODE: begin
                  cur_mode = bstc_mode_type'(csr_data[1:0]);
                  clear_stream();
               end
               CSR_DIRECTION: begin
                  cur_dir = csr_data[0];
                  clear_stream();
               end
               CSR_XOR_KEY: cur_key = csr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) predict_request(req_in_byte, req_in_last);

         // Compare each accepted response with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (predicted_outputs.size() == 0) begin
               $error("response with nothing predicted: out_byte %h", rsp_out_byte);
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               bad = 0;
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte mismatch: expected %h, actual %h",
                         want.data, rsp_out_byte);
                  bad = 1;
               end
               if (rsp_out_valid !== want.valid) begin
                  $error("out_valid mismatch: expected %b, actual %b",
                         want.valid, rsp_out_valid);
                  bad = 1;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last mismatch: expected %b, actual %b",
                         want.last, rsp_out_last);
                  bad = 1;
               end
               if (rsp_codec_error !== want.err) begin
                  $error("codec_error mismatch: expected %b, actual %b",
                         want.err, rsp_codec_error);
                  bad = 1;
               end
               if (bad) mismatch_count++;
            end
         end
      end
      outstanding = predicted_outputs.size();
   end

endmodule

// File: dv/tb_byte_stream_text_codec_unit.sv
`timescale 1ns / 1ps

module tb_byte_stream_text_codec_unit;
   import bstc_pkg::*;

   // Index past the end of the register list; a write there must do nothing.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int RANDOM_REQUESTS = 430;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_out_last;
   logic        rsp_codec_error;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   int mismatch_count;
   int outstanding;

   // Requests of the stream being planned, and whether it ends with last.
   logic [7:0] stream_bytes[$];
   bit         stream_ends;
   bit         no_gaps = 0;

   always #5 clock = ~clock;

   byte_stream_text_codec_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_last    (rsp_out_last),
      .rsp_codec_error (rsp_codec_error),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   codec_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_last    (rsp_out_last),
      .rsp_codec_error (rsp_codec_error),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_b64_char();
      int r;
      r = $urandom_range(0, 63);
      if (r < 26) return 8'("A" + r);
      if (r < 52) return 8'("a" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      if (r == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int n;
      n = $urandom_range(0, 15);
      if (n < 10) return 8'("0" + n);
      if ($urandom_range(0, 1) == 1) return 8'("A" + n - 10);
      return 8'("a" + n - 10);
   endfunction

   // Random gap before each request, with a rare mid-stream pause until every predicted response has arrived.
   task automatic send_request(input logic [7:0] b, input logic lst);
      int gap;
      bit drain;
      drain = ($urandom_range(0, 149) == 0);
      gap = pick_gap();
      if (gap > 0 || drain) begin
         @(negedge clock);
         req_valid <= 1'b0;
         if (gap > 1) repeat (gap - 1) @(negedge clock);
         while (drain && outstanding != 0) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= lst;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending and waits until the block has nothing left in flight.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++) send_request(s[i], ends && i == s.len() - 1);
   endtask

   // Plans one stream: well-formed text for the decoders with some noise,
   // truncation and odd lengths; raw bytes otherwise.
   task automatic plan_stream(input bstc_mode_type m, input logic d);
      int groups;
      int base;
      int r;
      stream_bytes.delete();
      if (m == MODE_BASE64 && d == DIR_DECODE) begin
         groups = $urandom_range(1, 5);
         repeat (4 * groups) stream_bytes.push_back(rand_b64_char());
         base = stream_bytes.size() - 4;
         r = $urandom_range(0, 9);
         if (r < 2) begin
            stream_bytes[base + 2] = PAD_CHAR;
            stream_bytes[base + 3] = PAD_CHAR;
         end else if (r == 2) begin
            stream_bytes[base + 3] = PAD_CHAR;
         end else if (r == 3) begin
            stream_bytes[base + 2] = PAD_CHAR;
         end
         if ($urandom_range(0, 9) == 0)
            stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = rand_byte();
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) void'(stream_bytes.pop_back());
      end else if (m == MODE_HEX && d == DIR_DECODE) begin
         repeat (2 * $urandom_range(1, 8)) stream_bytes.push_back(rand_hex_char());
         if ($urandom_range(0, 9) == 0)
            stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = rand_byte();
         if ($urandom_range(0, 5) == 0) void'(stream_bytes.pop_back());
      end else if (m == MODE_BASE64) begin
         repeat ($urandom_range(1, 10)) stream_bytes.push_back(rand_byte());
      end else begin
         repeat ($urandom_range(1, 16)) stream_bytes.push_back(rand_byte());
      end
      stream_ends = ($urandom_range(0, 9) != 0);
   endtask

   // Response stall: quiet stretches, some long, then mostly short holds.
   initial begin
      int quiet;
      int hold;
      forever begin
         if ($urandom_range(0, 9) < 2) quiet = $urandom_range(60, 200);
         else quiet = $urandom_range(0, 6);
         repeat (quiet) @(negedge clock) rsp_stall <= 1'b0;
         if ($urandom_range(0, 19) == 0) hold = $urandom_range(15, 40);
         else hold = $urandom_range(1, 3);
         repeat (hold) @(negedge clock) rsp_stall <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("byte_stream_text_codec_unit verification failed");
      $finish;
   end

   initial begin
      bstc_mode_type m;
      logic          d;
      int            sent;
      int            r;
      sent = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Passthrough at reset settings.
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);

      // XOR with the reset key, wrapping the key position.
      settle();
      write_csr(CSR_MODE, {30'd0, MODE_XOR});
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hA5, 1'b0);
      send_request(8'h3C, 1'b0);
      send_request(8'h5A, 1'b1);
      settle();
      write_csr(CSR_XOR_KEY, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED, 32'h0000_0001);
      send_request(8'h81, 1'b1);

      // Base64 encode: a full group, then a one-byte final group.
      settle();
      write_csr(CSR_MODE, {30'd0, MODE_BASE64});
      write_csr(CSR_DIRECTION, {31'd0, DIR_ENCODE});
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h4D, 1'b1);

      // Base64 decode: unknown character with pad in the third place only,
      // two pads, and a stream that ends inside a group.
      settle();
      write_csr(CSR_DIRECTION, {31'd0, DIR_DECODE});
      send_text("T*=A", 1'b0);
      send_text("TQ==", 1'b1);
      send_text("AB", 1'b1);

      // Hex both ways; decode mixes cases, an unknown digit and an odd end.
      settle();
      write_csr(CSR_MODE, {30'd0, MODE_HEX});
      write_csr(CSR_DIRECTION, {31'd0, DIR_ENCODE});
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
      settle();
      write_csr(CSR_DIRECTION, {31'd0, DIR_DECODE});
      send_text("aF9Z3", 1'b1);

      // Random phases, each with its own register settings.
      while (sent < RANDOM_REQUESTS) begin
         settle();
         m = bstc_mode_type'($urandom_range(0, 3));
         d = 1'($urandom_range(0, 1));
         no_gaps = ($urandom_range(0, 3) == 0);
         write_csr(CSR_MODE, {30'd0, m});
         write_csr(CSR_DIRECTION, {31'd0, d});
         r = $urandom_range(0, 9);
         if (r == 0) write_csr(CSR_XOR_KEY, 32'h0000_0000);
         else if (r == 1) write_csr(CSR_XOR_KEY, 32'hFFFF_FFFF);
         else if (r < 5) write_csr(CSR_XOR_KEY, $urandom);
         repeat ($urandom_range(1, 4)) begin
            plan_stream(m, d);
            foreach (stream_bytes[i])
               send_request(stream_bytes[i],
                            stream_ends && i == stream_bytes.size() - 1);
            sent += stream_bytes.size();
         end
      end

      no_gaps = 0;
      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("byte_stream_text_codec_unit verification clean");
      else
         $display("byte_stream_text_codec_unit verification failed");
      $finish;
   end

endmodule

// File: byte_stream_text_codec_unit.f
hdl/bstc_pkg.sv
hdl/bstc_front.sv
hdl/bstc_queue.sv
hdl/bstc_back.sv
hdl/byte_stream_text_codec_unit.sv
dv/codec_stream_checker.sv
dv/tb_byte_stream_text_codec_unit.sv
